### rtl/u8s_pkg.sv
`timescale 1ns / 1ps

package u8s_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;
  } out_word_t;

  // One command for the back end: some replacement triplets first, then
  // some literal bytes taken from lit_bytes starting at lane zero.
  typedef struct packed {
    logic [2:0]      reps;
    logic [2:0]      lits;
    logic [3:0][7:0] lit_bytes;
    logic            fin;
  } cmd_t;

  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] ASCII_LIMIT = 8'h80;

  localparam logic [7:0] REP_BYTE0 = 8'hEF;
  localparam logic [7:0] REP_BYTE1 = 8'hBF;
  localparam logic [7:0] REP_BYTE2 = 8'hBD;

  localparam logic [1:0] REP_PHASE0 = 2'd0;
  localparam logic [1:0] REP_PHASE1 = 2'd1;
  localparam logic [1:0] REP_LAST_PHASE = 2'd2;

  localparam logic [2:0] LEN_BAD   = 3'd0;
  localparam logic [2:0] LEN_ASCII = 3'd1;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] n;
    if (b < ASCII_LIMIT) n = 3'd1;
    else if ((b & LEAD2_MASK) == LEAD2_CODE) n = 3'd2;
    else if ((b & LEAD3_MASK) == LEAD3_CODE) n = 3'd3;
    else if ((b & LEAD4_MASK) == LEAD4_CODE) n = 3'd4;
    else n = LEN_BAD;
    return n;
  endfunction

  function automatic logic [7:0] rep_byte(input logic [1:0] phase);
    logic [7:0] r;
    case (phase)
      REP_PHASE0: r = REP_BYTE0;
      REP_PHASE1: r = REP_BYTE1;
      default:    r = REP_BYTE2;
    endcase
    return r;
  endfunction

endpackage

### rtl/u8s_front.sv
`timescale 1ns / 1ps

module u8s_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  input  u8s_pkg::in_word_t  src_word,
  output logic               src_stall,
  input  logic               cmd_full,
  output logic               cmd_push,
  output u8s_pkg::cmd_t      cmd_word,
  output logic               idle
);

  logic [1:0] held_count, held_count_next;
  logic [2:0] expected_length, expected_length_next;
  logic [7:0] held_bytes [3];

  logic       accept;
  logic [7:0] b;
  logic       fin;
  logic       cont;
  logic [2:0] n;
  logic [2:0] count_ext;
  logic [2:0] reps;
  logic [2:0] lits;
  logic [3:0][7:0] lanes;
  logic       start;
  logic       store;
  logic       hold_lead;

  always_comb begin
    b         = src_word.in_byte;
    fin       = src_word.final_byte;
    accept    = src_valid && !cmd_full;
    cont      = (b & u8s_pkg::CONT_MASK) == u8s_pkg::CONT_CODE;
    n         = u8s_pkg::lead_length(b);
    count_ext = {1'b0, held_count};

    reps      = '0;
    lits      = '0;
    start     = 1'b0;
    store     = 1'b0;
    hold_lead = 1'b0;
    held_count_next      = held_count;
    expected_length_next = expected_length;

    // A completed sequence is the held bytes followed by the new byte.
    lanes[0] = (held_count > 2'd0) ? held_bytes[0] : b;
    lanes[1] = (held_count > 2'd1) ? held_bytes[1] : b;
    lanes[2] = (held_count > 2'd2) ? held_bytes[2] : b;
    lanes[3] = b;

    if (held_count == 2'd0) begin
      start = 1'b1;
    end else if (cont) begin
      if (count_ext + 3'd1 >= expected_length) begin
        lits = count_ext + 3'd1;
        held_count_next      = 2'd0;
        expected_length_next = 3'd0;
      end else if (fin) begin
        reps = count_ext + 3'd1;
        held_count_next      = 2'd0;
        expected_length_next = 3'd0;
      end else begin
        store = 1'b1;
        held_count_next = held_count + 2'd1;
      end
    end else begin
      // Held bytes are dropped and the failing byte starts over.
      reps  = count_ext;
      start = 1'b1;
      held_count_next      = 2'd0;
      expected_length_next = 3'd0;
    end

    if (start) begin
      if (n == u8s_pkg::LEN_BAD) begin
        reps = reps + 3'd1;
      end else if (n == u8s_pkg::LEN_ASCII) begin
        lits     = 3'd1;
        lanes[0] = b;
      end else if (fin) begin
        reps = reps + 3'd1;
      end else begin
        hold_lead = 1'b1;
        held_count_next      = 2'd1;
        expected_length_next = n;
      end
    end

    cmd_word.reps      = reps;
    cmd_word.lits      = lits;
    cmd_word.lit_bytes = lanes;
    cmd_word.fin       = fin;
    cmd_push  = accept && ((reps != 3'd0) || (lits != 3'd0));
    src_stall = cmd_full;
    idle      = held_count == 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 2'd0;
      expected_length <= 3'd0;
    end else if (accept) begin
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && hold_lead) held_bytes[0] <= b;
    if (accept && store) held_bytes[held_count] <= b;
  end

endmodule

### rtl/u8s_cmd_fifo.sv
`timescale 1ns / 1ps

module u8s_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  u8s_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output u8s_pkg::cmd_t pop_data
);

  u8s_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    level;

  assign full      = level == 2'd2;
  assign pop_valid = level != 2'd0;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) level <= level + 2'd1;
      else if (pop && !push) level <= level - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

### rtl/u8s_back.sv
`timescale 1ns / 1ps

module u8s_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  u8s_pkg::cmd_t      cmd_word,
  output logic               cmd_pop,
  output logic               dst_valid,
  output u8s_pkg::out_word_t dst_word,
  input  logic               dst_stall
);

  logic [1:0] rep_done;
  logic [1:0] phase;
  logic [1:0] lit_idx;

  logic       in_rep;
  logic [7:0] cur_byte;
  logic       last;
  logic       fire;

  always_comb begin
    in_rep = {1'b0, rep_done} < cmd_word.reps;
    if (in_rep) begin
      cur_byte = u8s_pkg::rep_byte(phase);
      last = ({1'b0, rep_done} + 3'd1 == cmd_word.reps) &&
             (phase == u8s_pkg::REP_LAST_PHASE) && (cmd_word.lits == 3'd0);
    end else begin
      cur_byte = cmd_word.lit_bytes[lit_idx];
      last = ({1'b0, lit_idx} + 3'd1) == cmd_word.lits;
    end
    // The output register takes a new word whenever it is empty or drains.
    fire    = cmd_valid && (!dst_valid || !dst_stall);
    cmd_pop = fire && last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rep_done  <= 2'd0;
      phase     <= u8s_pkg::REP_PHASE0;
      lit_idx   <= 2'd0;
      dst_valid <= 1'b0;
    end else begin
      if (fire) begin
        dst_valid <= 1'b1;
        if (last) begin
          rep_done <= 2'd0;
          phase    <= u8s_pkg::REP_PHASE0;
          lit_idx  <= 2'd0;
        end else if (in_rep) begin
          if (phase == u8s_pkg::REP_LAST_PHASE) begin
            phase    <= u8s_pkg::REP_PHASE0;
            rep_done <= rep_done + 2'd1;
          end else begin
            phase <= phase + 2'd1;
          end
        end else begin
          lit_idx <= lit_idx + 2'd1;
        end
      end else if (!dst_stall) begin
        dst_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dst_word.out_byte   <= cur_byte;
      dst_word.run_end    <= last;
      dst_word.stream_end <= last && cmd_word.fin;
    end
  end

endmodule

### rtl/utf8_stream_sanitizer_core.sv
`timescale 1ns / 1ps
// UTF-8 stream sanitizer.
// Input channel src_*: one raw byte per word with a final_byte mark on the
// last byte of a string. Output channel dst_*: one sanitized byte per word,
// with run_end on the last byte caused by an input byte and stream_end on
// the last byte of the string. Both use valid/stall; a word moves when valid
// is high and stall is low.
// The front end classifies each byte and queues a command in a two-entry
// queue; the back end expands commands into output bytes, one per cycle
// while dst_stall allows, into an output register. A byte that passes
// straight through is registered in the queue and then in the output
// register. Held bytes of a multi-byte sequence come out together when the
// sequence completes. Intake is one byte per cycle while the queue has room;
// the output runs at one byte per cycle while not stalled, and a replacement
// (EF BF BD) is three output bytes, so a stream of bad bytes is output-bound.
// A stalled output holds its word; the queue then fills and src_stall rises.
// Reset clears the held sequence, the queue and the output register.
module utf8_stream_sanitizer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  input  u8s_pkg::in_word_t  src_word,
  output logic               src_stall,
  output logic               dst_valid,
  output u8s_pkg::out_word_t dst_word,
  input  logic               dst_stall
);

  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_pop;
  logic          cmd_valid;
  u8s_pkg::cmd_t cmd_in;
  u8s_pkg::cmd_t cmd_out;
  logic          front_idle;

  u8s_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_word  (src_word),
    .src_stall (src_stall),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_word  (cmd_in),
    .idle      (front_idle)
  );

  u8s_cmd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_valid (cmd_valid),
    .pop_data  (cmd_out)
  );

  u8s_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_word  (cmd_out),
    .cmd_pop   (cmd_pop),
    .dst_valid (dst_valid),
    .dst_word  (dst_word),
    .dst_stall (dst_stall)
  );

  a_stream_end_is_run_end: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_word.stream_end |-> dst_word.run_end)
    else $error("stream_end without run_end");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("command queue overflow");

  a_final_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    src_valid && !src_stall && src_word.final_byte |=> front_idle)
    else $error("sequence still held after final byte");

endmodule
